>>> rtl/core/md5h_pkg.sv
// MD5 hash package: sequencer state codes, padding phases, initial chaining
// words, round constant table, rotate and message index schedules.
// Used by md5h_round and md5_message_hash; no dependencies.
package md5h_pkg;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    PH_MARK = 4'b0001,
    PH_FILL = 4'b0010,
    PH_HI   = 4'b0100,
    PH_END  = 4'b1000
  } phase_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [31:0] PAD_MARK = 32'h00000080;
  localparam logic [2:0]  FULL_BYTES = 3'd4;
  localparam logic [3:0]  LEN_LO_POS = 4'd14;
  localparam logic [3:0]  LAST_POS   = 4'd15;
  localparam logic [5:0]  LAST_ROUND = 6'd63;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
      2'd2:    g = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
      default: g = 4'((r[3:0] << 3) - r[3:0]);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] pad_word(input logic [31:0] word, input logic [2:0] n);
    logic [31:0] p;
    case (n)
      3'd0:    p = PAD_MARK;
      3'd1:    p = {16'h0000, 8'h80, word[7:0]};
      3'd2:    p = {8'h00, 8'h80, word[15:0]};
      3'd3:    p = {8'h80, word[23:0]};
      default: p = word;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/md5h_round.sv
// MD5 round unit: one of the 64 compression rounds, selected by round index.
// Depends on md5h_pkg for the round constant and rotate schedule.
module md5h_round (
  input  logic [5:0]  round,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] w,
  output logic [31:0] new_a,
  output logic [31:0] new_b,
  output logic [31:0] new_c,
  output logic [31:0] new_d
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;

  always_comb begin
    case (round[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  assign sum   = a + f + w + md5h_pkg::round_k(round);
  assign dbl   = {sum, sum} << md5h_pkg::rot_amt(round);
  assign new_a = d;
  assign new_b = b + dbl[63:32];
  assign new_c = b;
  assign new_d = c;

endmodule

>>> rtl/core/md5_message_hash.sv
// MD5 message hash top level: word intake, padding sequencer, 16-word block
// buffer and chaining words around one shared round unit.
// Depends on md5h_pkg and md5h_round.
//
//   channel  signals                                                  direction
//   input    in_valid in_stall message_word word_bytes final_word    in (in_stall out)
//   output   out_valid out_stall digest_a..digest_d                   out (out_stall in)
//
// A completed 16-word block runs 64 rounds on the round unit, then one fold.
// A final word is followed by its padding words, one or two blocks, and a
// load of the digest register.
// Reset restores the initial chaining words and an empty message.
// A stalled digest holds the sequencer before the load; input stays stalled meanwhile.
module md5_message_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] message_word,
  input  logic [2:0]  word_bytes,
  input  logic        final_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_a,
  output logic [31:0] digest_b,
  output logic [31:0] digest_c,
  output logic [31:0] digest_d
);

  md5h_pkg::state_t state, state_next;
  md5h_pkg::phase_t phase;

  logic [31:0] block_words [16];
  logic [3:0]  pos;
  logic [63:0] bit_length;
  logic        padding;
  logic [5:0]  round;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] work_a, work_b, work_c, work_d;
  logic [31:0] rnd_a, rnd_b, rnd_c, rnd_d;

  logic        accept;
  logic        push;
  logic [31:0] push_data;
  logic [2:0]  nbytes;
  logic        load_out;

  assign in_stall = (state != md5h_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign nbytes   = (word_bytes > md5h_pkg::FULL_BYTES) ? md5h_pkg::FULL_BYTES : word_bytes;
  assign push     = accept || (state == md5h_pkg::S_PAD);
  assign load_out = (state == md5h_pkg::S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    if (state == md5h_pkg::S_PAD) begin
      case (phase)
        md5h_pkg::PH_MARK: push_data = md5h_pkg::PAD_MARK;
        md5h_pkg::PH_FILL: push_data = (pos == md5h_pkg::LEN_LO_POS) ? bit_length[31:0] : '0;
        default:           push_data = bit_length[63:32];
      endcase
    end else if (final_word) begin
      push_data = md5h_pkg::pad_word(message_word, nbytes);
    end else begin
      push_data = message_word;
    end
  end

  md5h_round u_round (
    .round (round),
    .a     (work_a),
    .b     (work_b),
    .c     (work_c),
    .d     (work_d),
    .w     (block_words[md5h_pkg::msg_index(round)]),
    .new_a (rnd_a),
    .new_b (rnd_b),
    .new_c (rnd_c),
    .new_d (rnd_d)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      md5h_pkg::S_IDLE: begin
        if (accept) begin
          if (pos == md5h_pkg::LAST_POS) state_next = md5h_pkg::S_ROUND;
          else if (final_word) state_next = md5h_pkg::S_PAD;
        end
      end
      md5h_pkg::S_PAD: begin
        if (pos == md5h_pkg::LAST_POS) state_next = md5h_pkg::S_ROUND;
      end
      md5h_pkg::S_ROUND: begin
        if (round == md5h_pkg::LAST_ROUND) state_next = md5h_pkg::S_FOLD;
      end
      md5h_pkg::S_FOLD: begin
        if (!padding) state_next = md5h_pkg::S_IDLE;
        else if (phase == md5h_pkg::PH_END) state_next = md5h_pkg::S_DONE;
        else state_next = md5h_pkg::S_PAD;
      end
      md5h_pkg::S_DONE: begin
        if (load_out) state_next = md5h_pkg::S_IDLE;
      end
      default: state_next = md5h_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      block_words[pos] <= push_data;
    end
    if (push && pos == md5h_pkg::LAST_POS) begin
      work_a <= chain_a;
      work_b <= chain_b;
      work_c <= chain_c;
      work_d <= chain_d;
    end else if (state == md5h_pkg::S_ROUND) begin
      work_a <= rnd_a;
      work_b <= rnd_b;
      work_c <= rnd_c;
      work_d <= rnd_d;
    end
    if (load_out) begin
      digest_a <= chain_a;
      digest_b <= chain_b;
      digest_c <= chain_c;
      digest_d <= chain_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= md5h_pkg::S_IDLE;
      phase      <= md5h_pkg::PH_FILL;
      padding    <= 1'b0;
      pos        <= '0;
      round      <= '0;
      bit_length <= '0;
      out_valid  <= 1'b0;
      chain_a    <= md5h_pkg::INIT_A;
      chain_b    <= md5h_pkg::INIT_B;
      chain_c    <= md5h_pkg::INIT_C;
      chain_d    <= md5h_pkg::INIT_D;
    end else begin
      state <= state_next;
      if (push) begin
        pos <= pos + 4'd1;
      end
      if (accept) begin
        if (final_word) begin
          bit_length <= bit_length + (64'(nbytes) << 3);
          padding    <= 1'b1;
          phase      <= (nbytes == md5h_pkg::FULL_BYTES) ? md5h_pkg::PH_MARK
                                                         : md5h_pkg::PH_FILL;
        end else begin
          bit_length <= bit_length + 64'd32;
        end
      end
      if (state == md5h_pkg::S_PAD) begin
        case (phase)
          md5h_pkg::PH_MARK: phase <= md5h_pkg::PH_FILL;
          md5h_pkg::PH_FILL: begin
            if (pos == md5h_pkg::LEN_LO_POS) phase <= md5h_pkg::PH_HI;
          end
          default: phase <= md5h_pkg::PH_END;
        endcase
      end
      if (state == md5h_pkg::S_ROUND) begin
        round <= round + 6'd1;
      end
      if (state == md5h_pkg::S_FOLD) begin
        chain_a <= chain_a + work_a;
        chain_b <= chain_b + work_b;
        chain_c <= chain_c + work_c;
        chain_d <= chain_d + work_d;
      end
      if (load_out) begin
        out_valid  <= 1'b1;
        padding    <= 1'b0;
        bit_length <= '0;
        chain_a    <= md5h_pkg::INIT_A;
        chain_b    <= md5h_pkg::INIT_B;
        chain_c    <= md5h_pkg::INIT_C;
        chain_d    <= md5h_pkg::INIT_D;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/md5h_check.sv
// MD5 hash port checker: timing relations between input and digest transfers.
// Bound to md5_message_hash; sees its ports only.
module md5h_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        final_word,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_a,
  input logic [31:0] digest_d
);

  a_final_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_word |=> in_stall)
    else $error("input not stalled after final word transfer");

  a_no_early_digest: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_word |=> !$rose(out_valid))
    else $error("digest appeared right after final word");

  a_digest_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("digest loaded while input side idle");

  a_digest_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_a) && $stable(digest_d))
    else $error("stalled digest changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("digest valid after reset");

endmodule

bind md5_message_hash md5h_check u_md5h_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .final_word (final_word),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .digest_a   (digest_a),
  .digest_d   (digest_d)
);
